// ===== hdl/csb_pkg.sv =====
// shared types and constants for the clipped sprite blitter
package csb_pkg;

  localparam int unsigned CoordW = 10;
  localparam int unsigned OriginW = 11;
  localparam int unsigned PixW = 8;
  localparam int unsigned AddrW = 16;
  localparam int unsigned OpW = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned TableDepth = 256;
  localparam int unsigned TableIdxW = 8;

  typedef enum logic [OpW-1:0] {
    OP_BEGIN = 2'd0,
    OP_PIXEL = 2'd1,
    OP_TABLE = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CLIP_LEFT   = 2'd0,
    REG_CLIP_TOP    = 2'd1,
    REG_CLIP_RIGHT  = 2'd2,
    REG_CLIP_BOTTOM = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic                 en;
    logic [TableIdxW-1:0] index;
    logic [PixW-1:0]      entry;
  } tbl_wr_t;

  typedef struct packed {
    logic                 en;
    logic [TableIdxW-1:0] index;
  } tbl_rd_t;

endpackage

// ===== hdl/csb_table.sv =====
// 256-entry translation table with registered read
module csb_table
  import csb_pkg::*;
(
  input  logic            clk_i,
  input  tbl_wr_t         wr_i,
  input  tbl_rd_t         rd_i,
  output logic [PixW-1:0] rd_data_o
);

  logic [PixW-1:0] mem_q [TableDepth];
  logic [PixW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.index] <= wr_i.entry;
    end
    if (rd_i.en) begin
      rd_data_q <= mem_q[rd_i.index];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/clipped_sprite_blitter.sv =====
// clipped sprite blitter top level: sprite state, clip test and frame buffer write output
//
// usage: items arrive on the in channel (valid/ready). a begin item latches the
// sprite origin, size and mode bits and restarts the pixel position. pixel items
// follow in row order and give at most one frame buffer write each on the out
// channel (write_address_o, write_pixel_o). table items load the translation
// table. clip registers are written through cfg_we_i/cfg_index_i/cfg_wdata_i;
// the user must write them only while the block is idle; the block does not enforce it.
// a kept pixel passes the middle stage (table read and clip test), then the
// address multiply into the output register, before it appears on the out channel.
// throughput: one item per cycle, set by the single table read port, unless the output stalls.
// reset clears the clip registers, the held sprite state and the pipeline
// valids; the table holds no defined value until written.
// when the receiver stalls, the output register holds its item and one more
// item waits in the middle stage; in_ready_o drops only when both are full.
module clipped_sprite_blitter
  import csb_pkg::*;
#(
  parameter int SCREEN_W = 320
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,

  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [CfgDataW-1:0]       cfg_wdata_i,

  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [OpW-1:0]            op_i,
  input  logic signed [OriginW-1:0] origin_x_i,
  input  logic signed [OriginW-1:0] origin_y_i,
  input  logic [CoordW-1:0]         sprite_width_i,
  input  logic [CoordW-1:0]         sprite_height_i,
  input  logic                      transparent_mode_i,
  input  logic                      background_mode_i,
  input  logic                      table_enable_i,
  input  logic [PixW-1:0]           source_pixel_i,
  input  logic [PixW-1:0]           dest_pixel_i,
  input  logic [TableIdxW-1:0]      table_index_i,
  input  logic [PixW-1:0]           table_entry_i,

  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [AddrW-1:0]          write_address_o,
  output logic [PixW-1:0]           write_pixel_o
);

  localparam int unsigned SwW = $clog2(SCREEN_W + 1);
  localparam int unsigned SumW = SwW + OriginW + 1;

  // configuration
  logic [CoordW-1:0] clip_left_q, clip_top_q, clip_right_q, clip_bottom_q;

  // held sprite state
  logic signed [OriginW-1:0] held_origin_x_q, held_origin_y_q;
  logic [CoordW-1:0]         held_width_q, held_height_q;
  logic                      mode_transp_q, mode_bg_q, mode_table_q;
  logic [CoordW-1:0]         column_count_q, row_count_q;

  // middle stage
  logic                 s1_valid_q;
  logic [OriginW-1:0]   s1_col_q, s1_row_q;
  logic [PixW-1:0]      s1_src_q;
  logic                 s1_use_table_q;
  logic [PixW-1:0]      tbl_rd_data;

  // output register
  logic                 out_valid_q;
  logic [AddrW-1:0]     write_address_q;
  logic [PixW-1:0]      write_pixel_q;

  logic                 in_acc, out_free, s1_move;
  logic                 is_begin, is_pixel, is_table;
  logic                 pix_active, keep;
  logic [CoordW:0]      col_next;
  logic signed [OriginW:0] col_pos, row_pos;
  tbl_wr_t              tbl_wr;
  tbl_rd_t              tbl_rd;
  logic [SumW-1:0]      addr_sum;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  assign is_begin = (op_e'(op_i) == OP_BEGIN);
  assign is_pixel = (op_e'(op_i) == OP_PIXEL);
  assign is_table = (op_e'(op_i) == OP_TABLE);

  assign pix_active = (held_width_q != '0) && (row_count_q < held_height_q);
  assign col_next   = {1'b0, column_count_q} + (CoordW+1)'(1);

  assign col_pos = {held_origin_x_q[OriginW-1], held_origin_x_q}
                 + $signed({2'b00, column_count_q});
  assign row_pos = {held_origin_y_q[OriginW-1], held_origin_y_q}
                 + $signed({2'b00, row_count_q});

  always_comb begin
    keep = 1'b1;
    if (col_pos < $signed({2'b00, clip_left_q}) || col_pos > $signed({2'b00, clip_right_q}) ||
        row_pos < $signed({2'b00, clip_top_q}) || row_pos > $signed({2'b00, clip_bottom_q})) begin
      keep = 1'b0;
    end
    if (mode_transp_q && (source_pixel_i == '0)) begin
      keep = 1'b0;
    end
  end

  assign tbl_wr.en    = in_acc && is_table;
  assign tbl_wr.index = table_index_i;
  assign tbl_wr.entry = table_entry_i;
  assign tbl_rd.en    = in_acc && is_pixel;
  assign tbl_rd.index = mode_bg_q ? dest_pixel_i : source_pixel_i;

  csb_table u_table (
    .clk_i     (clk_i),
    .wr_i      (tbl_wr),
    .rd_i      (tbl_rd),
    .rd_data_o (tbl_rd_data)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_left_q   <= '0;
      clip_top_q    <= '0;
      clip_right_q  <= '0;
      clip_bottom_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_CLIP_LEFT:   clip_left_q   <= cfg_wdata_i;
        REG_CLIP_TOP:    clip_top_q    <= cfg_wdata_i;
        REG_CLIP_RIGHT:  clip_right_q  <= cfg_wdata_i;
        REG_CLIP_BOTTOM: clip_bottom_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // sprite state and position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_origin_x_q <= '0;
      held_origin_y_q <= '0;
      held_width_q    <= '0;
      held_height_q   <= '0;
      mode_transp_q   <= 1'b0;
      mode_bg_q       <= 1'b0;
      mode_table_q    <= 1'b0;
      column_count_q  <= '0;
      row_count_q     <= '0;
    end else if (in_acc) begin
      if (is_begin) begin
        held_origin_x_q <= origin_x_i;
        held_origin_y_q <= origin_y_i;
        held_width_q    <= sprite_width_i;
        held_height_q   <= sprite_height_i;
        mode_transp_q   <= transparent_mode_i;
        mode_bg_q       <= background_mode_i;
        mode_table_q    <= table_enable_i;
        column_count_q  <= '0;
        row_count_q     <= '0;
      end else if (is_pixel && pix_active) begin
        if (col_next >= {1'b0, held_width_q}) begin
          column_count_q <= '0;
          row_count_q    <= row_count_q + CoordW'(1);
        end else begin
          column_count_q <= col_next[CoordW-1:0];
        end
      end
    end
  end

  // middle stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_acc && is_pixel && pix_active && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && is_pixel) begin
      s1_col_q       <= col_pos[OriginW-1:0];
      s1_row_q       <= row_pos[OriginW-1:0];
      s1_src_q       <= source_pixel_i;
      s1_use_table_q <= mode_table_q;
    end
  end

  // address and pixel select into the output register
  assign addr_sum = SumW'(s1_row_q) * SumW'(SCREEN_W) + SumW'(s1_col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      write_address_q <= addr_sum[AddrW-1:0];
      write_pixel_q   <= s1_use_table_q ? tbl_rd_data : s1_src_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign write_address_o = write_address_q;
  assign write_pixel_o   = write_pixel_q;

  // checks
  a_begin_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (op_e'(op_i) == OP_BEGIN))
      |=> (column_count_q == '0) && (row_count_q == '0))
    else $error("begin item did not restart the pixel position");

  a_column_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_width_q == '0) || (column_count_q < held_width_q))
    else $error("column position beyond sprite width");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_count_q <= held_height_q)
    else $error("row position beyond sprite height");

  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while both stages are stalled");

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for clipped_sprite_blitter: directed and random item streams with a predictor
module testbench;
  import csb_pkg::*;

  localparam int ScreenW = 320;
  localparam int CycleLimit = 300000;
  localparam int HoldCycles = 80;
  localparam int MaxReports = 10;

  typedef struct {
    op_e                       op;
    logic signed [OriginW-1:0] org_x;
    logic signed [OriginW-1:0] org_y;
    logic [CoordW-1:0]         width;
    logic [CoordW-1:0]         height;
    logic                      transparent;
    logic                      background;
    logic                      use_table;
    logic [PixW-1:0]           src;
    logic [PixW-1:0]           dst;
    logic [TableIdxW-1:0]      tbl_index;
    logic [PixW-1:0]           tbl_entry;
  } blit_item_t;

  typedef struct {
    logic [AddrW-1:0] address;
    logic [PixW-1:0]  pixel;
  } fb_write_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  cfg_reg_e                  cfg_index_i = REG_CLIP_LEFT;
  logic [CfgDataW-1:0]       cfg_wdata_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  op_e                       op_i = OP_NONE;
  logic signed [OriginW-1:0] origin_x_i = '0;
  logic signed [OriginW-1:0] origin_y_i = '0;
  logic [CoordW-1:0]         sprite_width_i = '0;
  logic [CoordW-1:0]         sprite_height_i = '0;
  logic                      transparent_mode_i = 1'b0;
  logic                      background_mode_i = 1'b0;
  logic                      table_enable_i = 1'b0;
  logic [PixW-1:0]           source_pixel_i = '0;
  logic [PixW-1:0]           dest_pixel_i = '0;
  logic [TableIdxW-1:0]      table_index_i = '0;
  logic [PixW-1:0]           table_entry_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [AddrW-1:0]          write_address_o;
  logic [PixW-1:0]           write_pixel_o;

  blit_item_t  pending_items[$];
  fb_write_t   fb_writes_due[$];
  blit_item_t  offered;
  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  logic        hold_req = 1'b0;

  // predictor state
  logic [CoordW-1:0]         clip_l = '0, clip_t = '0, clip_r = '0, clip_b = '0;
  logic [CoordW-1:0]         col_pos = '0, row_pos = '0, spr_w = '0, spr_h = '0;
  logic signed [OriginW-1:0] spr_x = '0, spr_y = '0;
  logic                      mode_transparent = 1'b0, mode_background = 1'b0;
  logic                      mode_table = 1'b0;
  logic [PixW-1:0]           color_lut [TableDepth];

  // generator view of the sprite modes and loaded table entries
  logic                      gen_table = 1'b0, gen_background = 1'b0;
  bit                        lut_loaded [TableDepth];
  logic [TableIdxW-1:0]      loaded_list[$];

  clipped_sprite_blitter #(
    .SCREEN_W(ScreenW)
  ) uut (
    .*
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // driver and predictor
  always @(posedge clk_i or negedge rst_ni) begin
    int col, row;
    logic [PixW-1:0] pix;
    fb_write_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        case (offered.op)
          OP_BEGIN: begin
            spr_x = offered.org_x;
            spr_y = offered.org_y;
            spr_w = offered.width;
            spr_h = offered.height;
            mode_transparent = offered.transparent;
            mode_background = offered.background;
            mode_table = offered.use_table;
            col_pos = '0;
            row_pos = '0;
          end
          OP_TABLE: color_lut[offered.tbl_index] = offered.tbl_entry;
          OP_PIXEL: begin
            if (spr_w != '0 && row_pos < spr_h) begin
              col = int'(spr_x) + int'(col_pos);
              row = int'(spr_y) + int'(row_pos);
              if (col_pos == spr_w - CoordW'(1)) begin
                col_pos = '0;
                row_pos = row_pos + CoordW'(1);
              end else begin
                col_pos = col_pos + CoordW'(1);
              end
              if (col >= int'(clip_l) && col <= int'(clip_r) &&
                  row >= int'(clip_t) && row <= int'(clip_b) &&
                  !(mode_transparent && offered.src == '0)) begin
                if (!mode_table) pix = offered.src;
                else if (mode_background) pix = color_lut[offered.dst];
                else pix = color_lut[offered.src];
                nxt.address = AddrW'(row * ScreenW + col);
                nxt.pixel = pix;
                fb_writes_due.push_back(nxt);
              end
            end
          end
          default: ;
        endcase
        items_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          offered = pending_items.pop_front();
          in_valid_i <= 1'b1;
          op_i <= offered.op;
          origin_x_i <= offered.org_x;
          origin_y_i <= offered.org_y;
          sprite_width_i <= offered.width;
          sprite_height_i <= offered.height;
          transparent_mode_i <= offered.transparent;
          background_mode_i <= offered.background;
          table_enable_i <= offered.use_table;
          source_pixel_i <= offered.src;
          dest_pixel_i <= offered.dst;
          table_index_i <= offered.tbl_index;
          table_entry_i <= offered.tbl_entry;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    fb_write_t due;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (fb_writes_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("unexpected write: address %0d pixel %0d", write_address_o, write_pixel_o);
        end else begin
          due = fb_writes_due.pop_front();
          if (write_address_o !== due.address || write_pixel_o !== due.pixel) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("write mismatch: address exp %0d got %0d, pixel exp %0d got %0d",
                       due.address, write_address_o, due.pixel, write_pixel_o);
          end
        end
      end
      out_ready_i <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic blit_item_t blank_item(op_e op);
    blit_item_t it;
    it.op = op;
    it.org_x = OriginW'($urandom_range(2047));
    it.org_y = OriginW'($urandom_range(2047));
    it.width = CoordW'($urandom_range(1023));
    it.height = CoordW'($urandom_range(1023));
    it.transparent = 1'($urandom_range(1));
    it.background = 1'($urandom_range(1));
    it.use_table = 1'($urandom_range(1));
    it.src = PixW'($urandom_range(255));
    it.dst = PixW'($urandom_range(255));
    it.tbl_index = TableIdxW'($urandom_range(255));
    it.tbl_entry = PixW'($urandom_range(255));
    return it;
  endfunction

  function automatic int pick_source();
    return ($urandom_range(7) == 0) ? 0 : $urandom_range(255);
  endfunction

  // origin close to the clip window, now and then anywhere
  function automatic int near_window(int lo, int hi);
    int span, v;
    if ($urandom_range(9) == 0) return $urandom_range(2047) - 1024;
    span = (hi >= lo) ? hi - lo : 0;
    v = lo - 6 + $urandom_range(span + 12);
    if (v > 1023) v = 1023;
    if (v < -1024) v = -1024;
    return v;
  endfunction

  task automatic queue_item(blit_item_t it);
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic send_begin(int ox, int oy, int w, int h, bit tr, bit bg, bit te);
    blit_item_t it = blank_item(OP_BEGIN);
    it.org_x = OriginW'(ox);
    it.org_y = OriginW'(oy);
    it.width = CoordW'(w);
    it.height = CoordW'(h);
    it.transparent = tr;
    it.background = bg;
    it.use_table = te;
    gen_table = te;
    gen_background = bg;
    queue_item(it);
  endtask

  // in table mode, pixel items are steered so that table reads hit only loaded entries
  task automatic send_pixel(int src, int dst);
    blit_item_t it = blank_item(OP_PIXEL);
    it.src = PixW'(src);
    it.dst = PixW'(dst);
    if (gen_table && gen_background && !lut_loaded[it.dst])
      it.dst = loaded_list[$urandom_range(loaded_list.size() - 1)];
    if (gen_table && !gen_background && !lut_loaded[it.src])
      it.src = loaded_list[$urandom_range(loaded_list.size() - 1)];
    queue_item(it);
  endtask

  task automatic send_table(int idx, int ent);
    blit_item_t it = blank_item(OP_TABLE);
    it.tbl_index = TableIdxW'(idx);
    it.tbl_entry = PixW'(ent);
    if (!lut_loaded[it.tbl_index]) begin
      lut_loaded[it.tbl_index] = 1'b1;
      loaded_list.push_back(it.tbl_index);
    end
    queue_item(it);
  endtask

  task automatic write_reg(cfg_reg_e idx, int value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= CfgDataW'(value);
  endtask

  task automatic set_clip(int l, int t, int r, int b);
    write_reg(REG_CLIP_LEFT, l);
    write_reg(REG_CLIP_TOP, t);
    write_reg(REG_CLIP_RIGHT, r);
    write_reg(REG_CLIP_BOTTOM, b);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    clip_l = CoordW'(l);
    clip_t = CoordW'(t);
    clip_r = CoordW'(r);
    clip_b = CoordW'(b);
  endtask

  task automatic drain();
    while (items_taken != items_queued) @(posedge clk_i);
    while (fb_writes_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic random_phase(int l, int t, int r, int b, int gap, int stall, int n,
                              bit pressure);
    int count, kind, w, h, npix, shape;
    count = 0;
    set_clip(l, t, r, b);
    send_gap_pct = gap;
    recv_stall_pct = stall;
    while (count < n) begin
      kind = $urandom_range(99);
      if (kind < 10) begin
        send_table($urandom_range(255), $urandom_range(255));
        count++;
      end else if (kind < 14) begin
        queue_item(blank_item(OP_NONE));
      end else if (kind < 20) begin
        send_pixel(pick_source(), $urandom_range(255));
        count++;
      end else begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 5);
        if ($urandom_range(19) == 0) w = ($urandom_range(1) == 1) ? 0 : 1023;
        send_begin(near_window(l, r), near_window(t, b), w, h,
                   1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
        npix = (w == 0 || w > 8) ? $urandom_range(1, 6) : w * h;
        shape = $urandom_range(9);
        if (shape == 0) npix += $urandom_range(1, 3);
        else if (shape == 1) npix = $urandom_range(npix - 1);
        for (int i = 0; i < npix; i++) send_pixel(pick_source(), $urandom_range(255));
        count += 1 + npix;
      end
    end
    if (pressure) begin
      @(posedge clk_i);
      hold_req <= 1'b1;
      @(posedge clk_i);
      hold_req <= 1'b0;
    end
    drain();
  endtask

  initial begin
    int l, t;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_clip(0, 0, 1023, 1023);

    // pixel before any sprite, unused op, table loads at the extremes
    send_pixel(255, 255);
    queue_item(blank_item(OP_NONE));
    send_table(0, 255);
    send_table(255, 0);
    send_table(8'hA5, 8'h5A);
    send_table(8'h5A, 8'hA5);
    // sprite hanging off the top left corner, one pixel past its end
    send_begin(-2, -1, 3, 2, 1'b0, 1'b0, 1'b0);
    for (int i = 0; i < 7; i++) send_pixel(8'h11 + i, 8'hEE - i);
    // bottom right corner, transparent zero with table mode on, then a pixel clipped past the right edge
    send_begin(1023, 1023, 1023, 1023, 1'b1, 1'b0, 1'b1);
    send_pixel(0, 8'hFF);
    send_pixel(8'hA5, 0);
    // zero width sprite
    send_begin(-1024, -1024, 0, 5, 1'b0, 1'b0, 1'b0);
    send_pixel(8'h42, 8'h24);
    // background lookup of the old screen value
    send_begin(10, 20, 2, 1, 1'b0, 1'b1, 1'b1);
    send_pixel(0, 0);
    send_pixel(8'h33, 255);
    // background mode without the table passes the source through
    send_begin(5, 5, 1, 1, 1'b1, 1'b1, 1'b0);
    send_pixel(8'h80, 8'h7F);
    drain();

    random_phase(16, 8, 200, 120, 0, 0, 70, 1'b1);
    l = $urandom_range(900);
    t = $urandom_range(900);
    random_phase(l, t, l + $urandom_range(100), t + $urandom_range(100), 50, 0, 70, 1'b0);
    random_phase(0, 0, 1023, 1023, 0, 50, 70, 1'b0);
    random_phase(1000, 1010, 1023, 1023, 23, 23, 60, 1'b0);
    random_phase(500, 40, 499, 80, 23, 23, 20, 1'b0);
    l = $urandom_range(900);
    t = $urandom_range(900);
    random_phase(l, t, l + $urandom_range(100), t + $urandom_range(100), 23, 23, 70, 1'b0);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
